// File: hw/rtl/spd_pkg.sv
// Shared types and constants for the signed point-polygon distance core.
package spd_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FIELD_W = 32;
  localparam int DIFF_W = FIELD_W + 1;
  localparam int MUL_W = DIFF_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W = PROD_W;
  localparam int NUM_W = 134;
  localparam int DEN_W = 131;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_DOT0, DP_DOT1,
    DP_LEN0, DP_LEN1,
    DP_DA0, DP_DA1,
    DP_DB0, DP_DB1,
    DP_CR0, DP_CR1,
    DP_SQ0, DP_SQ1, DP_SQ2,
    DP_DIVINIT, DP_DIV,
    DP_UPD,
    DP_SQINIT, DP_SQRT,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] edge_ax;
    logic [FIELD_W-1:0] edge_ay;
    logic [FIELD_W-1:0] edge_bx;
    logic [FIELD_W-1:0] edge_by;
    logic [FIELD_W-1:0] query_x;
    logic [FIELD_W-1:0] query_y;
    logic               last_edge;
  } edge_t;

  typedef struct packed {
    logic [FIELD_W-1:0] signed_distance;
    logic               inside_flag;
    logic               saturated_flag;
  } result_t;

endpackage

// File: hw/rtl/spd_in_if.sv
// Edge request channel: valid/ready handshake with one polygon edge as payload.
interface spd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] edge_ax;
  logic signed [31:0] edge_ay;
  logic signed [31:0] edge_bx;
  logic signed [31:0] edge_by;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic               last_edge;

  modport source (output valid, edge_ax, edge_ay, edge_bx, edge_by, query_x, query_y,
                  last_edge, input ready);
  modport sink   (input valid, edge_ax, edge_ay, edge_bx, edge_by, query_x, query_y,
                  last_edge, output ready);
endinterface

// File: hw/rtl/spd_out_if.sv
// Result channel: valid/ready handshake carrying the signed distance.
interface spd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] signed_distance;
  logic               inside_flag;
  logic               saturated_flag;

  modport source (output valid, signed_distance, inside_flag, saturated_flag,
                  input ready);
  modport sink   (input valid, signed_distance, inside_flag, saturated_flag,
                  output ready);
endinterface

// File: hw/rtl/signed_point_polygon_distance_core.sv
// Top level of the signed point-to-polygon distance core.
// Usage: send the polygon's edges one request at a time on edge_i, each with
// endpoints a and b and the query point, all signed Q16.16. Mark the final edge
// with last_edge; that request produces one result on result_o: floor of the
// distance in Q16.16, negated when the point is inside (odd crossing count),
// clipped to 0x7fffffff in magnitude with saturated_flag set.
// Sequence: each accepted edge runs the products on the shared multiplier (dot,
// length, end-point distances, cross product and its square), a divider setup
// step, the restoring divider and an update step before edge_i.ready rises
// again. The last edge first adds a square root and a step that writes the
// output register; that step waits until the output register is free.
// The output register frees the core: the next polygon's edges are taken while
// a result waits for result_o.ready; only a second result stalls the core.
// Reset clears the parity, the running minimum (to infinity) and the output valid flag.
module signed_point_polygon_distance_core #(
  parameter int COORD_WIDTH = spd_pkg::COORD_WIDTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  spd_in_if.sink    edge_i,
  spd_out_if.source result_o
);

  spd_pkg::edge_t      edge_req;
  spd_pkg::result_t    res;
  spd_pkg::dp_status_t status;
  spd_pkg::dp_op_e     op;
  logic                load;
  logic                in_ready;
  logic                out_valid;

  assign edge_req.edge_ax   = edge_i.edge_ax;
  assign edge_req.edge_ay   = edge_i.edge_ay;
  assign edge_req.edge_bx   = edge_i.edge_bx;
  assign edge_req.edge_by   = edge_i.edge_by;
  assign edge_req.query_x   = edge_i.query_x;
  assign edge_req.query_y   = edge_i.query_y;
  assign edge_req.last_edge = edge_i.last_edge;
  assign edge_i.ready       = in_ready;

  spd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (edge_i.valid),
    .in_ready_o (in_ready),
    .load_o     (load),
    .status_i   (status),
    .op_o       (op)
  );

  spd_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .edge_i      (edge_req),
    .op_i        (op),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .result_o    (res)
  );

  assign result_o.valid           = out_valid;
  assign result_o.signed_distance = res.signed_distance;
  assign result_o.inside_flag     = res.inside_flag;
  assign result_o.saturated_flag  = res.saturated_flag;

endmodule

// File: hw/rtl/spd_ctrl.sv
// Sequencer: steps the datapath through products, division, update, square root and output write.
module spd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                load_o,
  input  spd_pkg::dp_status_t status_i,
  output spd_pkg::dp_op_e     op_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_DIV, ST_UPD, ST_SQRT, ST_EMIT
  } state_e;

  state_e           state_q;
  spd_pkg::dp_op_e  op_q;
  logic [5:0]       cnt_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign load_o     = in_valid_i && in_ready_o;
  assign op_o       = op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= spd_pkg::DP_NOP;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (load_o) begin
            state_q <= ST_MAC;
            op_q    <= spd_pkg::DP_DOT0;
          end
        end
        ST_MAC: begin
          unique case (op_q)
            spd_pkg::DP_DOT0: op_q <= spd_pkg::DP_DOT1;
            spd_pkg::DP_DOT1: op_q <= spd_pkg::DP_LEN0;
            spd_pkg::DP_LEN0: op_q <= spd_pkg::DP_LEN1;
            spd_pkg::DP_LEN1: op_q <= spd_pkg::DP_DA0;
            spd_pkg::DP_DA0:  op_q <= spd_pkg::DP_DA1;
            spd_pkg::DP_DA1:  op_q <= spd_pkg::DP_DB0;
            spd_pkg::DP_DB0:  op_q <= spd_pkg::DP_DB1;
            spd_pkg::DP_DB1:  op_q <= spd_pkg::DP_CR0;
            spd_pkg::DP_CR0:  op_q <= spd_pkg::DP_CR1;
            spd_pkg::DP_CR1:  op_q <= spd_pkg::DP_SQ0;
            spd_pkg::DP_SQ0:  op_q <= spd_pkg::DP_SQ1;
            spd_pkg::DP_SQ1:  op_q <= spd_pkg::DP_SQ2;
            spd_pkg::DP_SQ2: begin
              op_q    <= spd_pkg::DP_DIVINIT;
              state_q <= ST_DIV;
            end
            default: begin
              op_q    <= spd_pkg::DP_NOP;
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_DIV: begin
          if (op_q == spd_pkg::DP_DIVINIT) begin
            op_q  <= spd_pkg::DP_DIV;
            cnt_q <= 6'd63;
          end else if (cnt_q == '0) begin
            op_q    <= spd_pkg::DP_UPD;
            state_q <= ST_UPD;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_UPD: begin
          if (status_i.last) begin
            op_q    <= spd_pkg::DP_SQINIT;
            state_q <= ST_SQRT;
          end else begin
            op_q    <= spd_pkg::DP_NOP;
            state_q <= ST_IDLE;
          end
        end
        ST_SQRT: begin
          if (op_q == spd_pkg::DP_SQINIT) begin
            op_q  <= spd_pkg::DP_SQRT;
            cnt_q <= 6'd31;
          end else if (cnt_q == '0) begin
            op_q    <= spd_pkg::DP_EMIT;
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_EMIT: begin
          // datapath writes the output register in the same cycle as out_free lets this state exit
          if (status_i.out_free) begin
            op_q    <= spd_pkg::DP_NOP;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          op_q    <= spd_pkg::DP_NOP;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/spd_dp.sv
// Datapath: shared multiplier, accumulators, restoring divider, square root, output register.
module spd_dp #(
  parameter int COORD_WIDTH = spd_pkg::COORD_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  spd_pkg::edge_t      edge_i,
  input  spd_pkg::dp_op_e     op_i,
  output spd_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spd_pkg::result_t    result_o
);

  localparam int FW = spd_pkg::FIELD_W;
  localparam int EW = (COORD_WIDTH < FW) ? COORD_WIDTH : FW;
  localparam int SH = FW - EW;
  localparam int DW = spd_pkg::DIFF_W;
  localparam int MW = spd_pkg::MUL_W;
  localparam int PW = spd_pkg::PROD_W;
  localparam int AW = spd_pkg::ACC_W;
  localparam int NW = spd_pkg::NUM_W;
  localparam int QW = spd_pkg::DEN_W;

  function automatic logic signed [FW-1:0] sext(input logic [FW-1:0] f);
    logic [FW-1:0] t;
    t = f << SH;
    return $signed(t) >>> SH;
  endfunction

  logic signed [FW-1:0] ax, ay, bx, by, qx, qy;
  assign ax = sext(edge_i.edge_ax);
  assign ay = sext(edge_i.edge_ay);
  assign bx = sext(edge_i.edge_bx);
  assign by = sext(edge_i.edge_by);
  assign qx = sext(edge_i.query_x);
  assign qy = sext(edge_i.query_y);

  logic signed [DW-1:0] wx_q, wy_q, dx_q, dy_q, ex_q, ey_q;
  logic                 last_q;
  logic signed [AW-1:0] dot_q, len_q, da_q, db_q, cr_q;
  logic [NW-1:0]        num_q, rem_q;
  logic [QW-1:0]        den_q;
  logic [63:0]          quo_q;
  logic                 ovf_q;
  logic                 parity_q;
  logic [63:0]          min_q;
  logic [63:0]          x_q, r_q, bit_q;
  logic                 out_valid_q;
  spd_pkg::result_t     result_q;

  // magnitude of the cross product, split into two limbs for squaring
  logic signed [AW-1:0] cr_abs;
  logic [32:0]          cr_lo, cr_hi;
  assign cr_abs = cr_q[AW-1] ? -cr_q : cr_q;
  assign cr_lo  = cr_abs[32:0];
  assign cr_hi  = cr_abs[65:33];

  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (op_i)
      spd_pkg::DP_DOT0: begin ma = MW'(wx_q); mb = MW'(dx_q); end
      spd_pkg::DP_DOT1: begin ma = MW'(wy_q); mb = MW'(dy_q); end
      spd_pkg::DP_LEN0: begin ma = MW'(dx_q); mb = MW'(dx_q); end
      spd_pkg::DP_LEN1: begin ma = MW'(dy_q); mb = MW'(dy_q); end
      spd_pkg::DP_DA0:  begin ma = MW'(wx_q); mb = MW'(wx_q); end
      spd_pkg::DP_DA1:  begin ma = MW'(wy_q); mb = MW'(wy_q); end
      spd_pkg::DP_DB0:  begin ma = MW'(ex_q); mb = MW'(ex_q); end
      spd_pkg::DP_DB1:  begin ma = MW'(ey_q); mb = MW'(ey_q); end
      spd_pkg::DP_CR0:  begin ma = MW'(wx_q); mb = MW'(dy_q); end
      spd_pkg::DP_CR1:  begin ma = MW'(wy_q); mb = MW'(dx_q); end
      spd_pkg::DP_SQ0:  begin ma = $signed({1'b0, cr_lo}); mb = $signed({1'b0, cr_lo}); end
      spd_pkg::DP_SQ1:  begin ma = $signed({1'b0, cr_lo}); mb = $signed({1'b0, cr_hi}); end
      spd_pkg::DP_SQ2:  begin ma = $signed({1'b0, cr_hi}); mb = $signed({1'b0, cr_hi}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign prod = ma * mb;

  logic [NW-1:0] prod_u;
  assign prod_u = NW'(unsigned'(prod));

  // divider step and overflow check
  logic [NW-1:0] den_ext, len_top;
  logic          div_ge;
  assign den_ext = NW'(den_q);
  assign div_ge  = rem_q >= den_ext;
  assign len_top = NW'(unsigned'(len_q)) << 64;

  // square root step
  logic [63:0] sq_t;
  assign sq_t = r_q + bit_q;

  // squared distance of this edge
  logic signed [AW-1:0] dml;
  logic [63:0]          d2;
  logic                 crossing;
  assign dml = dot_q - len_q;
  always_comb begin
    if (dot_q[AW-1] || (dot_q == '0)) begin
      d2 = (da_q[AW-1:64] != '0) ? '1 : da_q[63:0];
    end else if (!dml[AW-1]) begin
      d2 = (db_q[AW-1:64] != '0) ? '1 : db_q[63:0];
    end else begin
      d2 = ovf_q ? '1 : quo_q;
    end
  end
  assign crossing = (wy_q[DW-1] != ey_q[DW-1]) &&
                    (dy_q[DW-1] ? (!cr_q[AW-1] && (cr_q != '0)) : cr_q[AW-1]);

  logic        out_free;
  logic        emit;
  logic        sat;
  logic [31:0] mag;
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (op_i == spd_pkg::DP_EMIT) && out_free;
  assign sat      = r_q[63:31] != '0;
  assign mag      = sat ? 32'h7fff_ffff : r_q[31:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      wx_q   <= DW'(qx) - DW'(ax);
      wy_q   <= DW'(qy) - DW'(ay);
      dx_q   <= DW'(bx) - DW'(ax);
      dy_q   <= DW'(by) - DW'(ay);
      ex_q   <= DW'(qx) - DW'(bx);
      ey_q   <= DW'(qy) - DW'(by);
      last_q <= edge_i.last_edge;
      dot_q  <= '0;
      len_q  <= '0;
      da_q   <= '0;
      db_q   <= '0;
      cr_q   <= '0;
      num_q  <= '0;
    end
    unique case (op_i)
      spd_pkg::DP_DOT0, spd_pkg::DP_DOT1: dot_q <= dot_q + prod;
      spd_pkg::DP_LEN0, spd_pkg::DP_LEN1: len_q <= len_q + prod;
      spd_pkg::DP_DA0,  spd_pkg::DP_DA1:  da_q  <= da_q + prod;
      spd_pkg::DP_DB0,  spd_pkg::DP_DB1:  db_q  <= db_q + prod;
      spd_pkg::DP_CR0: cr_q <= cr_q + prod;
      spd_pkg::DP_CR1: cr_q <= cr_q - prod;
      spd_pkg::DP_SQ0: num_q <= num_q + prod_u;
      spd_pkg::DP_SQ1: num_q <= num_q + (prod_u << 34);
      spd_pkg::DP_SQ2: num_q <= num_q + (prod_u << 66);
      spd_pkg::DP_DIVINIT: begin
        ovf_q <= num_q >= len_top;
        rem_q <= num_q;
        den_q <= QW'(unsigned'(len_q)) << 63;
        quo_q <= '0;
      end
      spd_pkg::DP_DIV: begin
        if (div_ge) rem_q <= rem_q - den_ext;
        quo_q <= {quo_q[62:0], div_ge};
        den_q <= den_q >> 1;
      end
      spd_pkg::DP_SQINIT: begin
        x_q   <= min_q;
        r_q   <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      spd_pkg::DP_SQRT: begin
        if (x_q >= sq_t) begin
          x_q <= x_q - sq_t;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
    if (emit) begin
      result_q.signed_distance <= parity_q ? (32'd0 - mag) : mag;
      result_q.inside_flag     <= parity_q;
      result_q.saturated_flag  <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      min_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == spd_pkg::DP_UPD) begin
        if (crossing) parity_q <= !parity_q;
        if (d2 < min_q) min_q <= d2;
      end
      if (emit) begin
        parity_q    <= 1'b0;
        min_q       <= '1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.last     = last_q;
  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign result_o          = result_q;

endmodule

// File: hw/rtl/spd_checker.sv
// Port-level checks on the result channel, bound to the core's top level.
module spd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] distance,
  input logic        in_poly,
  input logic        saturated
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(distance) && $stable(in_poly) && $stable(saturated))
    else $error("result payload changed while stalled");

  a_sign_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (in_poly ? (distance[31] || (distance == 32'd0)) : !distance[31]))
    else $error("distance sign disagrees with inside flag");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |-> (distance == 32'h7fff_ffff) || (distance == 32'h8000_0001))
    else $error("saturated result not at full scale");

endmodule

bind signed_point_polygon_distance_core spd_checker u_spd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .distance  (result_o.signed_distance),
  .in_poly   (result_o.inside_flag),
  .saturated (result_o.saturated_flag)
);

// File: test/spd_distance_checker.sv
// Watches the edge and result channels, predicts each polygon result and compares.
module spd_distance_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  spd_in_if         edge_mon,
  spd_out_if        result_mon,
  output int        fail_count_o,
  output int        results_pending_o
);
  import spd_pkg::*;

  typedef logic signed [191:0] wide_t;
  localparam wide_t TWO_POW_64 = wide_t'(1) << 64;

  logic        parity_q;
  logic [63:0] min_dist2_q;
  result_t     expected_results[$];
  int          fail_count;

  assign fail_count_o      = fail_count;
  assign results_pending_o = expected_results.size();

  function automatic logic [63:0] clip64(wide_t v);
    return (v >= TWO_POW_64) ? '1 : v[63:0];
  endfunction

  // Squared distance from the point to the segment, Q32.32, held at all ones when huge.
  function automatic logic [63:0] segment_dist2(edge_t e);
    wide_t ax, ay, bx, by, px, py, dx, dy, wx, wy, dot, len, cr, num;
    ax = $signed(e.edge_ax);  ay = $signed(e.edge_ay);
    bx = $signed(e.edge_bx);  by = $signed(e.edge_by);
    px = $signed(e.query_x);  py = $signed(e.query_y);
    dx = bx - ax;  dy = by - ay;  wx = px - ax;  wy = py - ay;
    dot = wx * dx + wy * dy;
    len = dx * dx + dy * dy;
    if (dot <= 0) return clip64(wx * wx + wy * wy);
    if (dot >= len) return clip64((px - bx) * (px - bx) + (py - by) * (py - by));
    cr = wx * dy - wy * dx;
    if (cr < 0) cr = -cr;
    num = cr * cr;
    if (num >= (len << 64)) return '1;
    return clip64(num / len);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] x, r, b;
    x = n;  r = 0;  b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic crosses_ray(edge_t e);
    wide_t ax, ay, bx, by, px, py, dy, diff;
    ax = $signed(e.edge_ax);  ay = $signed(e.edge_ay);
    bx = $signed(e.edge_bx);  by = $signed(e.edge_by);
    px = $signed(e.query_x);  py = $signed(e.query_y);
    if ((ay > py) == (by > py)) return 1'b0;
    dy = by - ay;
    diff = (px - ax) * dy - (bx - ax) * (py - ay);
    return (dy > 0) ? (diff < 0) : (diff > 0);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    edge_t       e;
    result_t     r, want;
    logic [63:0] d2, m, cur_min;
    logic        par;
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      min_dist2_q <= '1;
      fail_count  <= 0;
    end else begin
      if (edge_mon.valid && edge_mon.ready) begin
        e = '{edge_mon.edge_ax, edge_mon.edge_ay, edge_mon.edge_bx, edge_mon.edge_by,
              edge_mon.query_x, edge_mon.query_y, edge_mon.last_edge};
        par = parity_q ^ crosses_ray(e);
        d2 = segment_dist2(e);
        cur_min = (d2 < min_dist2_q) ? d2 : min_dist2_q;
        if (e.last_edge) begin
          m = floor_sqrt(cur_min);
          r.saturated_flag = (m > 64'h7fff_ffff);
          if (r.saturated_flag) m = 64'h7fff_ffff;
          r.signed_distance = par ? -m[31:0] : m[31:0];
          r.inside_flag = par;
          expected_results.insert(expected_results.size(), r);
          parity_q    <= 1'b0;
          min_dist2_q <= '1;
        end else begin
          parity_q    <= par;
          min_dist2_q <= cur_min;
        end
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: dist=%0d inside=%0b sat=%0b",
                     result_mon.signed_distance, result_mon.inside_flag,
                     result_mon.saturated_flag);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (result_mon.signed_distance !== want.signed_distance ||
              result_mon.inside_flag !== want.inside_flag ||
              result_mon.saturated_flag !== want.saturated_flag) begin
            if (fail_count < 10)
              $display({"mismatch: exp dist=%0d inside=%0b sat=%0b, ",
                        "got dist=%0d inside=%0b sat=%0b"},
                       $signed(want.signed_distance), want.inside_flag, want.saturated_flag,
                       result_mon.signed_distance, result_mon.inside_flag,
                       result_mon.saturated_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: test/tb_signed_point_polygon_distance_core.sv
// Stimulus and verdict for the signed point-polygon distance core.
module tb_signed_point_polygon_distance_core;
  import spd_pkg::*;

  localparam int    CYCLE_LIMIT = 1000000;
  localparam int    HOLD_CYCLES = 4000;
  localparam int    ONE = 65536;
  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, results_pending, edges_sent, sender_idle_pct;
  int   cycle_count = 0;
  bit   hold_started = 1'b0;
  int   hold_left = 0;

  spd_in_if  edge_if ();
  spd_out_if result_if ();

  signed_point_polygon_distance_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .edge_i   (edge_if),
    .result_o (result_if)
  );

  spd_distance_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .edge_mon          (edge_if),
    .result_mon        (result_if),
    .fail_count_o      (fail_count),
    .results_pending_o (results_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off to back up the core and an always-ready window.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (!hold_started && edges_sent >= 300) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (edges_sent >= 600 && edges_sent < 800) begin
      result_if.ready <= 1'b1;
    end else begin
      result_if.ready <= ($urandom_range(99) >= 27);
    end
  end

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_edge(input edge_t e);
    if ($urandom_range(99) < sender_idle_pct) begin
      edge_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    edge_if.valid     <= 1'b1;
    edge_if.edge_ax   <= e.edge_ax;
    edge_if.edge_ay   <= e.edge_ay;
    edge_if.edge_bx   <= e.edge_bx;
    edge_if.edge_by   <= e.edge_by;
    edge_if.query_x   <= e.query_x;
    edge_if.query_y   <= e.query_y;
    edge_if.last_edge <= e.last_edge;
    @(posedge clk_i);
    while (!edge_if.ready) @(posedge clk_i);
    edges_sent++;
    sender_idle_pct = (edges_sent >= 600 && edges_sent < 800) ? 0 : 27;
  endtask

  task automatic send_segment(input logic [31:0] ax, ay, bx, by, px, py, input bit last);
    send_edge('{ax, ay, bx, by, px, py, last});
  endtask

  // Square of half-width one unit, edges counter-clockwise, closed.
  task automatic send_square(input logic [31:0] px, py);
    send_segment(-ONE, -ONE,  ONE, -ONE, px, py, 1'b0);
    send_segment( ONE, -ONE,  ONE,  ONE, px, py, 1'b0);
    send_segment( ONE,  ONE, -ONE,  ONE, px, py, 1'b0);
    send_segment(-ONE,  ONE, -ONE, -ONE, px, py, 1'b1);
  endtask

  function automatic logic [31:0] rand_coord(int shift);
    return $signed($urandom) >>> shift;
  endfunction

  task automatic send_random_polygon();
    logic [31:0] vx[8], vy[8], qx, qy;
    int n, shift, mode;
    n = $urandom_range(1, 8);
    mode = $urandom_range(99);
    shift = (mode < 10) ? 0 : $urandom_range(8, 20);
    for (int i = 0; i < n; i++) begin
      vx[i] = rand_coord(shift);
      vy[i] = rand_coord(shift);
      if ($urandom_range(9) == 0 && i > 0) vy[i] = vy[i-1];  // horizontal edge
      if ($urandom_range(19) == 0 && i > 0) begin              // repeated vertex
        vx[i] = vx[i-1];
        vy[i] = vy[i-1];
      end
    end
    qx = rand_coord(shift);
    qy = rand_coord(shift);
    case ($urandom_range(7))
      0: qy = vy[$urandom_range(n-1)];  // ray through a vertex
      1: begin
        qx = vx[0];
        qy = vy[0];
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (mode >= 95) begin
        qx = rand_coord(shift);  // noise: point moves between edges
        qy = rand_coord(shift);
      end
      send_segment(vx[i], vy[i], vx[(i+1)%n], vy[(i+1)%n], qx, qy, i == n-1);
    end
  endtask

  initial begin
    edge_if.valid     = 1'b0;
    edge_if.edge_ax   = '0;
    edge_if.edge_ay   = '0;
    edge_if.edge_bx   = '0;
    edge_if.edge_by   = '0;
    edge_if.query_x   = '0;
    edge_if.query_y   = '0;
    edge_if.last_edge = 1'b0;
    edges_sent = 0;
    sender_idle_pct = 27;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_square(32'd0, 32'd0);               // inside
    send_square(3 * ONE, 32'd0);             // outside
    send_square(ONE, ONE / 2);               // on an edge
    send_square(-ONE, ONE);                  // ray through a vertex
    send_segment(ONE, ONE, ONE, ONE, 32'd0, 32'd0, 1'b1);           // degenerate edge
    send_segment(-ONE, 32'd0, ONE, 32'd0, 32'd0, 32'd0, 1'b1);      // horizontal
    send_segment(MINC, MINC, MAXC, MAXC, MAXC, MINC, 1'b1);         // saturates
    send_segment(MAXC, MINC, MINC, MAXC, MINC, MINC, 1'b1);
    send_segment(MINC, MAXC, MINC, MINC, MAXC, 32'd0, 1'b1);        // long vertical
    send_segment(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1);         // zero distance

    while (edges_sent < 1250) send_random_polygon();
    edge_if.valid <= 1'b0;

    // let the checker log the final request before polling its queue
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && results_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: signed_point_polygon_distance_core.f
hw/rtl/spd_pkg.sv
hw/rtl/spd_in_if.sv
hw/rtl/spd_out_if.sv
hw/rtl/spd_ctrl.sv
hw/rtl/spd_dp.sv
hw/rtl/signed_point_polygon_distance_core.sv
hw/rtl/spd_checker.sv
test/spd_distance_checker.sv
test/tb_signed_point_polygon_distance_core.sv
